// ===== hw/rtl/accumulator_machine_executor_assert.svh =====
// assertion macros shared by the accumulator machine executor modules
`ifndef ACCUMULATOR_MACHINE_EXECUTOR_ASSERT_SVH
`define ACCUMULATOR_MACHINE_EXECUTOR_ASSERT_SVH

// condition holds in the same cycle, checked on clock, off during reset
`define AME_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the antecedent
`define AME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ame_pkg.sv =====
// types, opcodes and constants of the accumulator machine executor
package ame_pkg;

   localparam int ADDR_WIDTH_DEFAULT = 8;
   localparam int WORD_WIDTH_DEFAULT = 32;

   localparam int REQ_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 32;
   localparam int OP_WIDTH       = 4;
   localparam int FIELD_ADDR_WIDTH = 8;
   localparam int IMM_WIDTH      = 32;
   localparam int SHOW_WIDTH     = 2;

   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_WIDTH-1:0] OP_SET   = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_LDR   = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_ADD   = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_INC   = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_DEC   = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_STR   = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_SHW   = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_PAUSE = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_END   = 4'd8;

   localparam logic [SHOW_WIDTH-1:0] SHOW_ACC = 2'd0;
   localparam logic [SHOW_WIDTH-1:0] SHOW_MAR = 2'd1;
   localparam logic [SHOW_WIDTH-1:0] SHOW_OP  = 2'd2;
   localparam logic [SHOW_WIDTH-1:0] SHOW_MEM = 2'd3;

   localparam logic KIND_VALUE = 1'b0;
   localparam logic KIND_HALT  = 1'b1;

   // one decoded instruction as it travels from front to back
   typedef struct packed {
      logic [OP_WIDTH-1:0]         op;
      logic [FIELD_ADDR_WIDTH-1:0] addr_a;
      logic signed [IMM_WIDTH-1:0] immediate;
      logic [FIELD_ADDR_WIDTH-1:0] addr_b;
      logic                        use_b;
      logic [FIELD_ADDR_WIDTH-1:0] addr_dst;
      logic                        store_sum;
      logic [SHOW_WIDTH-1:0]       show_what;
   } cmd_type;

   // queue head as the back end sees it
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

// ===== hw/rtl/ame_front.sv =====
// front end: accepts instructions, drops no-ops and everything after halt
module ame_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mode, addr_a, immediate, addr_b, use_b, addr_dst, store_sum, show_what
   input  logic [ame_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                              init_done,
   input  logic                              q_full,
   output logic                              q_push,
   output ame_pkg::cmd_type                  q_cmd
);
   import ame_pkg::*;

   logic    halted_ff;
   logic    halted_in;
   logic    accept;
   logic    executable;
   cmd_type cmd;

   always_comb begin
      cmd.op        = req_tdata[3:0];
      cmd.addr_a    = req_tdata[11:4];
      cmd.immediate = req_tdata[43:12];
      cmd.addr_b    = req_tdata[51:44];
      cmd.use_b     = req_tdata[52];
      cmd.addr_dst  = req_tdata[60:53];
      cmd.store_sum = req_tdata[61];
      cmd.show_what = req_tdata[63:62];
   end

   // after halt the queue state no longer matters, items are swallowed
   assign req_tready = !reset && init_done && (halted_ff || !q_full);
   assign accept     = req_tvalid && req_tready;
   assign executable = (cmd.op <= OP_END) && (cmd.op != OP_PAUSE);
   assign q_push     = accept && !halted_ff && executable;
   assign q_cmd      = cmd;
   assign halted_in  = halted_ff || (q_push && (cmd.op == OP_END));

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
      end else begin
         halted_ff <= halted_in;
      end
   end

endmodule

// ===== hw/rtl/ame_queue.sv =====
// two-entry instruction queue between front and back end
module ame_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ame_pkg::cmd_type        push_cmd,
   output logic                    full,
   input  logic                    pop,
   output ame_pkg::queue_head_type head
);
   import ame_pkg::*;

   `include "accumulator_machine_executor_assert.svh"

   localparam logic [QUEUE_COUNT_WIDTH-1:0] COUNT_FULL = QUEUE_COUNT_WIDTH'(QUEUE_DEPTH);

   cmd_type                       entries_ff [QUEUE_DEPTH];
   cmd_type                       entries_in [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]    wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]    wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]    rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0]    rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0]  count_ff;
   logic [QUEUE_COUNT_WIDTH-1:0]  count_in;

   assign full       = (count_ff == COUNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      entries_in = entries_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_cmd;
      end
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_COUNT_WIDTH'(push) - QUEUE_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `AME_ASSERT_NOW(a_queue_no_overflow, push && !pop, count_ff != COUNT_FULL, "queue overflow")
   `AME_ASSERT_NOW(a_queue_no_underflow, pop, count_ff != '0, "queue underflow")

endmodule

// ===== hw/rtl/ame_back.sv =====
// back end: executes instructions on the accumulator, address register and data memory
module ame_back #(
   parameter int ADDR_WIDTH = ame_pkg::ADDR_WIDTH_DEFAULT,
   parameter int WORD_WIDTH = ame_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ame_pkg::queue_head_type            head,
   output logic                               q_pop,
   output logic                               init_done,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // shown
   output logic [ame_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // kind
   output logic                               rsp_tuser
);
   import ame_pkg::*;

   `include "accumulator_machine_executor_assert.svh"

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ_B = 2'd2;
   localparam logic [1:0] ST_EXEC   = 2'd3;

   localparam int MEM_DEPTH = 1 << ADDR_WIDTH;
   localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   logic [WORD_WIDTH-1:0]     mem_array [MEM_DEPTH];
   logic [WORD_WIDTH-1:0]     rd_data_ff;

   logic [1:0]                state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [ADDR_WIDTH-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [WORD_WIDTH-1:0]     acc_ff, acc_in;
   logic [ADDR_WIDTH-1:0]     mar_ff, mar_in;
   logic [WORD_WIDTH-1:0]     opa_ff, opa_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_shown_ff, rsp_shown_in;

   logic                      rd_en;
   logic [ADDR_WIDTH-1:0]     rd_addr;
   logic                      wr_en;
   logic [ADDR_WIDTH-1:0]     wr_addr;
   logic [WORD_WIDTH-1:0]     wr_data;

   logic [ADDR_WIDTH-1:0]     addr_a, addr_b, addr_dst, head_a;
   logic [WORD_WIDTH-1:0]     imm_word, sum_word, inc_word, dec_word;
   logic                      out_free;

   assign addr_a   = ADDR_WIDTH'(cmd_ff.addr_a);
   assign addr_b   = ADDR_WIDTH'(cmd_ff.addr_b);
   assign addr_dst = ADDR_WIDTH'(cmd_ff.addr_dst);
   assign head_a   = ADDR_WIDTH'(head.cmd.addr_a);
   assign imm_word = WORD_WIDTH'(cmd_ff.immediate);
   // two-source add keeps mem[a] in opa, mem[b] arrives in the read register
   assign sum_word = (cmd_ff.use_b ? opa_ff : acc_ff) + rd_data_ff;
   assign inc_word = rd_data_ff + WORD_WIDTH'(1);
   assign dec_word = rd_data_ff - WORD_WIDTH'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign init_done  = (state_ff != ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_shown_ff;
   assign rsp_tuser  = rsp_kind_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      clr_cnt_in   = clr_cnt_ff;
      acc_in       = acc_ff;
      mar_in       = mar_ff;
      opa_in       = opa_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_shown_in = rsp_shown_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_a;
      wr_en        = 1'b0;
      wr_addr      = addr_a;
      wr_data      = acc_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = WORD_MIN;
            clr_cnt_in = clr_cnt_ff + ADDR_WIDTH'(1);
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               q_pop    = 1'b1;
               cmd_in   = head.cmd;
               rd_en    = 1'b1;
               rd_addr  = head_a;
               state_in = (head.cmd.op == OP_ADD && head.cmd.use_b) ? ST_READ_B : ST_EXEC;
            end
         end
         ST_READ_B: begin
            opa_in   = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = addr_b;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (cmd_ff.op)
               OP_SET: begin
                  mar_in  = addr_a;
                  wr_en   = 1'b1;
                  wr_data = imm_word;
               end
               OP_LDR: begin
                  mar_in = addr_a;
                  acc_in = rd_data_ff;
               end
               OP_ADD: begin
                  acc_in = sum_word;
                  mar_in = cmd_ff.use_b ? addr_b : addr_a;
                  if (cmd_ff.store_sum) begin
                     mar_in  = addr_dst;
                     wr_en   = 1'b1;
                     wr_addr = addr_dst;
                     wr_data = sum_word;
                  end
               end
               OP_INC: begin
                  mar_in  = addr_a;
                  acc_in  = inc_word;
                  wr_en   = 1'b1;
                  wr_data = inc_word;
               end
               OP_DEC: begin
                  mar_in  = addr_a;
                  acc_in  = dec_word;
                  wr_en   = 1'b1;
                  wr_data = dec_word;
               end
               OP_STR: begin
                  mar_in  = addr_a;
                  wr_en   = 1'b1;
                  wr_data = acc_ff;
               end
               OP_SHW: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_VALUE;
                     case (cmd_ff.show_what)
                        SHOW_ACC: rsp_shown_in = RSP_DATA_WIDTH'(signed'(acc_ff));
                        SHOW_MAR: rsp_shown_in = RSP_DATA_WIDTH'(mar_ff);
                        SHOW_OP:  rsp_shown_in = RSP_DATA_WIDTH'(OP_SHW);
                        default: begin
                           mar_in       = addr_a;
                           rsp_shown_in = RSP_DATA_WIDTH'(signed'(rd_data_ff));
                        end
                     endcase
                  end else begin
                     state_in = ST_EXEC;
                  end
               end
               OP_END: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_HALT;
                     rsp_shown_in = '0;
                  end else begin
                     state_in = ST_EXEC;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      opa_ff       <= opa_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_shown_ff <= rsp_shown_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         acc_ff       <= WORD_MIN;
         mar_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         acc_ff       <= acc_in;
         mar_ff       <= mar_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `AME_ASSERT_NOW(a_clear_quiet, state_ff == ST_CLEAR, !q_pop && !rsp_valid_ff, "activity during memory clear")
   `AME_ASSERT_NOW(a_read_b_only_add, state_ff == ST_READ_B, cmd_ff.op == OP_ADD && cmd_ff.use_b, "second read without two-source add")

endmodule

// ===== hw/rtl/accumulator_machine_executor.sv =====
// Accumulator machine executor: runs one decoded instruction per transaction.
// The req channel carries one instruction per transaction; SHW returns one
// rsp transaction with the shown value (tuser 0), END returns one with tuser 1
// and shown 0, after which every request is taken and dropped until reset.
// All other instructions return nothing.
// Flow: the front end places each request that it takes in a
// two-entry queue; PAUSE, unused opcodes and requests after halt never enter
// it. The back end works on one instruction at a time: memory read in IDLE,
// then execute and write back in EXEC, with a second read in READ_B between
// them for a two-source ADD, due to the single read port of the data memory.
// A request's result passes the queue, IDLE and EXEC into the output register.
// Reset: synchronous. Afterwards the data memory is swept to the most negative
// value, one word per cycle, all 2^ADDR_WIDTH words (256 by default); req_tready
// stays low until the sweep is done.
// Stall: the output register holds a result while rsp_tready is low; the back
// end waits only on a further result, so requests keep flowing until the queue
// fills.
module accumulator_machine_executor #(
   parameter int ADDR_WIDTH = ame_pkg::ADDR_WIDTH_DEFAULT,
   parameter int WORD_WIDTH = ame_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // mode[3:0], addr_a[11:4], immediate[43:12], addr_b[51:44], use_b[52],
   // addr_dst[60:53], store_sum[61], show_what[63:62]
   input  logic [ame_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // shown[31:0]
   output logic [ame_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // kind[0]
   output logic                               rsp_tuser
);
   import ame_pkg::*;

   logic           init_done;
   logic           q_full;
   logic           q_push;
   logic           q_pop;
   cmd_type        q_cmd;
   queue_head_type q_head;

   ame_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .init_done  (init_done),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   ame_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   ame_back #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_pop      (q_pop),
      .init_done  (init_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
